>>> hw/rtl/spcd_pkg.sv
// spcd_pkg: shared constants, types and the request record for the phase meter
// no dependencies
package spcd_pkg;
    localparam int SAMPLE_BITS = 24;
    localparam int FRAC_BITS   = 15;
    localparam int TIME_BITS   = 34;
    localparam int MAG_BITS    = SAMPLE_BITS;
    localparam int SQ_BITS     = 2 * MAG_BITS + 1;
    localparam int Q_BITS      = FRAC_BITS + 2;
    localparam int SUM_BITS    = 32;
    localparam int FLEN_BITS   = 16;
    localparam int CFG_IDX_BITS = 3;
    localparam int CFG_DATA_BITS = 34;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_LEN   = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_MONO_THR    = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_OUT_THR     = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_MIN_DUR     = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_DETECT_EN   = 3'd4;

    localparam logic [1:0] EV_NONE  = 2'd0;
    localparam logic [1:0] EV_START = 2'd1;
    localparam logic [1:0] EV_END   = 2'd2;

    // request handed from front to back
    typedef struct packed {
        logic                   flush;
        logic                   neg;
        logic                   zero;
        logic [SQ_BITS-1:0]     num;
        logic [SQ_BITS-1:0]     den;
    } t_req;
endpackage

>>> hw/rtl/spcd_front.sv
// spcd_front: accepts words, drops disabled flushes, forms magnitudes and squares
// depends on spcd_pkg
module spcd_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic                              i_req_type,
    input  logic signed [spcd_pkg::SAMPLE_BITS-1:0] i_left_sample,
    input  logic signed [spcd_pkg::SAMPLE_BITS-1:0] i_right_sample,
    input  logic                              i_detect_en,
    output logic                              o_q_valid,
    output spcd_pkg::t_req                    o_q_req,
    input  logic                              i_q_pop
);
    import spcd_pkg::*;

    // stage 1: magnitudes; stage 2: squares into queue
    logic                 r_s1_valid;
    logic                 r_s1_flush, r_s1_neg;
    logic [MAG_BITS-1:0]  r_l, r_r;
    t_req                 r_q [QUEUE_DEPTH];
    logic                 r_wp, r_rp;
    logic [1:0]           r_cnt;
    logic [1:0]           n_cnt;
    logic                 push, acc;
    logic [MAG_BITS-1:0]  lmag, rmag;
    t_req                 nreq;
    logic [2*MAG_BITS-1:0] ll, rr, lr;

    // keep a slot free for the word in stage 1
    assign o_stall = (r_cnt + {1'b0, r_s1_valid}) >= 2'(QUEUE_DEPTH);
    assign acc     = i_valid && !o_stall;
    assign lmag    = i_left_sample[SAMPLE_BITS-1] ? MAG_BITS'(-i_left_sample)
                                                  : MAG_BITS'(i_left_sample);
    assign rmag    = i_right_sample[SAMPLE_BITS-1] ? MAG_BITS'(-i_right_sample)
                                                   : MAG_BITS'(i_right_sample);
    assign ll = r_l * r_l;
    assign rr = r_r * r_r;
    assign lr = r_l * r_r;
    always_comb begin
        nreq.flush = r_s1_flush;
        nreq.neg   = r_s1_neg;
        nreq.den   = SQ_BITS'(ll) + SQ_BITS'(rr);
        nreq.num   = {lr, 1'b0};
        nreq.zero  = (r_l == '0) && (r_r == '0);
    end
    assign push      = r_s1_valid;
    assign o_q_valid = r_cnt != 2'd0;
    assign o_q_req   = r_q[r_rp];
    assign n_cnt     = r_cnt + {1'b0, push} - {1'b0, i_q_pop};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= '0;
        end else begin
            // a flush with detection off yields nothing and is dropped here
            r_s1_valid <= acc && !(i_req_type && !i_detect_en);
            if (push) r_wp <= !r_wp;
            if (i_q_pop) r_rp <= !r_rp;
            r_cnt <= n_cnt;
        end
    end
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_flush <= i_req_type;
            r_s1_neg   <= i_left_sample[SAMPLE_BITS-1] ^ i_right_sample[SAMPLE_BITS-1];
            r_l <= lmag;
            r_r <= rmag;
        end
        if (push) r_q[r_wp] <= nreq;
    end
endmodule

>>> hw/rtl/spcd_back.sv
// spcd_back: serial phase divider, frame accumulation, mean divider, detectors
// depends on spcd_pkg
module spcd_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_q_valid,
    input  spcd_pkg::t_req                    i_q_req,
    output logic                              o_q_pop,
    input  logic [spcd_pkg::FLEN_BITS-1:0]    i_frame_len,
    input  logic [14:0]                       i_mono_thr,
    input  logic signed [15:0]                i_out_thr,
    input  logic [spcd_pkg::TIME_BITS-1:0]    i_min_dur,
    input  logic                              i_detect_en,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic signed [15:0]                o_mean_phase,
    output logic [1:0]                        o_mono_event,
    output logic [spcd_pkg::TIME_BITS-1:0]    o_mono_time,
    output logic [spcd_pkg::TIME_BITS-1:0]    o_mono_length,
    output logic [1:0]                        o_out_event,
    output logic [spcd_pkg::TIME_BITS-1:0]    o_out_time,
    output logic [spcd_pkg::TIME_BITS-1:0]    o_out_length
);
    import spcd_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_PDIV = 5'b00010,
        ST_MDIV = 5'b00100,
        ST_DET  = 5'b01000,
        ST_OUT  = 5'b10000
    } t_state;

    t_state               r_st;
    t_req                 r_req;
    logic [SQ_BITS:0]     r_rem;
    logic [Q_BITS-1:0]    r_q;
    logic [5:0]           r_it;
    logic [FLEN_BITS-1:0] r_sif;
    logic [SUM_BITS-1:0]  r_sum;
    logic [TIME_BITS-1:0] r_fst;
    logic                 r_m_act, r_m_pend, r_o_act, r_o_pend;
    logic [TIME_BITS-1:0] r_m_beg, r_o_beg;
    logic [SUM_BITS-1:0]  r_mq, r_mr;
    logic                 r_mneg;
    logic [FLEN_BITS:0]   r_cntv;
    logic                 r_flush;
    logic signed [SUM_BITS:0] r_mean;
    logic [SQ_BITS:0]     rem_sh;
    logic [SUM_BITS:0]    mrem_sh;
    logic [SUM_BITS-1:0]  n_sum;
    logic [FLEN_BITS:0]   n_cnt, flen;
    logic signed [SUM_BITS-1:0] phase32;
    logic [TIME_BITS-1:0] fend, s_t, e_t;
    logic                 mx, ox;

    assign o_q_pop = (r_st == ST_IDLE) && i_q_valid;
    assign rem_sh  = {r_rem[SQ_BITS-1:0], 1'b0};
    assign mrem_sh = {r_mr, r_mq[SUM_BITS-1]};
    assign phase32 = r_req.zero ? SUM_BITS'(1 << FRAC_BITS)
                   : (r_req.neg ? -SUM_BITS'(r_q) : SUM_BITS'(r_q));
    assign n_sum   = r_sum + phase32;
    assign n_cnt   = {1'b0, r_sif} + 1'b1;
    assign flen    = (i_frame_len == '0) ? 17'd1 : {1'b0, i_frame_len};
    assign fend    = r_fst + TIME_BITS'(r_cntv);
    assign s_t     = r_fst;
    assign e_t     = r_flush ? r_fst : fend;
    assign mx      = !r_flush && (r_mean >= $signed({18'd0, i_mono_thr}));
    assign ox      = !r_flush && (r_mean < $signed({{17{i_out_thr[15]}}, i_out_thr}));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE;
            r_sif <= '0; r_sum <= '0; r_fst <= '0;
            r_m_act <= 1'b0; r_m_pend <= 1'b0; r_m_beg <= '0;
            r_o_act <= 1'b0; r_o_pend <= 1'b0; r_o_beg <= '0;
            o_valid <= 1'b0;
        end else begin
            unique case (r_st)
                ST_IDLE: begin
                    if (i_q_valid) begin
                        r_req <= i_q_req;
                        r_flush <= i_q_req.flush;
                        if (i_q_req.num >= i_q_req.den) begin
                            r_rem <= {1'b0, i_q_req.num - i_q_req.den};
                            r_q <= Q_BITS'(1);
                        end else begin
                            r_rem <= {1'b0, i_q_req.num};
                            r_q <= '0;
                        end
                        r_it <= '0;
                        r_st <= i_q_req.flush ? ST_DET : ST_PDIV;
                    end
                end
                ST_PDIV: begin
                    if (r_it != 6'(FRAC_BITS)) begin
                        if (rem_sh >= {1'b0, r_req.den}) begin
                            r_rem <= rem_sh - {1'b0, r_req.den};
                            r_q <= {r_q[Q_BITS-2:0], 1'b1};
                        end else begin
                            r_rem <= rem_sh;
                            r_q <= {r_q[Q_BITS-2:0], 1'b0};
                        end
                        r_it <= r_it + 1'b1;
                    end else if (n_cnt < flen) begin
                        r_sum <= n_sum;
                        r_sif <= n_cnt[FLEN_BITS-1:0];
                        r_st <= ST_IDLE;
                    end else begin
                        r_mneg <= n_sum[SUM_BITS-1];
                        r_mq <= n_sum[SUM_BITS-1] ? -n_sum : n_sum;
                        r_mr <= '0;
                        r_cntv <= n_cnt;
                        r_it <= '0;
                        r_st <= ST_MDIV;
                    end
                end
                ST_MDIV: begin
                    if (r_it != 6'(SUM_BITS)) begin
                        if (mrem_sh >= {16'd0, r_cntv}) begin
                            r_mr <= SUM_BITS'(mrem_sh - {16'd0, r_cntv});
                            r_mq <= {r_mq[SUM_BITS-2:0], 1'b1};
                        end else begin
                            r_mr <= mrem_sh[SUM_BITS-1:0];
                            r_mq <= {r_mq[SUM_BITS-2:0], 1'b0};
                        end
                        r_it <= r_it + 1'b1;
                    end else begin
                        r_mean <= r_mneg ? -$signed({1'b0, r_mq}) : $signed({1'b0, r_mq});
                        r_st <= ST_DET;
                    end
                end
                ST_DET: begin
                    o_mono_event <= EV_NONE; o_mono_time <= '0; o_mono_length <= '0;
                    o_out_event <= EV_NONE; o_out_time <= '0; o_out_length <= '0;
                    if (r_flush) o_mean_phase <= '0;
                    else if (r_mean > 33'sd32767) o_mean_phase <= 16'sh7fff;
                    else if (r_mean < -33'sd32768) o_mean_phase <= 16'sh8000;
                    else o_mean_phase <= 16'(r_mean);
                    if (r_flush || i_detect_en) begin
                        if (!r_m_act && mx) begin
                            r_m_act <= 1'b1; r_m_pend <= 1'b1; r_m_beg <= s_t;
                            if (e_t - s_t >= i_min_dur) begin
                                o_mono_event <= EV_START; o_mono_time <= s_t;
                                r_m_pend <= 1'b0;
                            end
                        end else if (r_m_act && mx && r_m_pend) begin
                            if (e_t - r_m_beg >= i_min_dur) begin
                                o_mono_event <= EV_START; o_mono_time <= r_m_beg;
                                r_m_pend <= 1'b0;
                            end
                        end else if (r_m_act && !mx) begin
                            if (s_t - r_m_beg >= i_min_dur) begin
                                o_mono_event <= EV_END; o_mono_time <= s_t;
                                o_mono_length <= s_t - r_m_beg;
                            end
                            r_m_act <= 1'b0;
                        end
                        if (!r_o_act && ox) begin
                            r_o_act <= 1'b1; r_o_pend <= 1'b1; r_o_beg <= s_t;
                            if (e_t - s_t >= i_min_dur) begin
                                o_out_event <= EV_START; o_out_time <= s_t;
                                r_o_pend <= 1'b0;
                            end
                        end else if (r_o_act && ox && r_o_pend) begin
                            if (e_t - r_o_beg >= i_min_dur) begin
                                o_out_event <= EV_START; o_out_time <= r_o_beg;
                                r_o_pend <= 1'b0;
                            end
                        end else if (r_o_act && !ox) begin
                            if (s_t - r_o_beg >= i_min_dur) begin
                                o_out_event <= EV_END; o_out_time <= s_t;
                                o_out_length <= s_t - r_o_beg;
                            end
                            r_o_act <= 1'b0;
                        end
                    end
                    if (!r_flush) begin
                        r_fst <= fend;
                        r_sif <= '0;
                        r_sum <= '0;
                    end
                    o_valid <= 1'b1;
                    r_st <= ST_OUT;
                end
                ST_OUT: begin
                    if (!i_stall) begin
                        o_valid <= 1'b0;
                        r_st <= ST_IDLE;
                    end
                end
                default: r_st <= ST_IDLE;
            endcase
        end
    end
endmodule

>>> hw/rtl/stereo_phase_correlation_detector_top.sv
// stereo_phase_correlation_detector_top: config registers, front end, queue, back end
// depends on spcd_pkg, spcd_front, spcd_back
//
// Input channel i_valid/o_stall carries one word: a stereo sample (req_type 0)
// or a flush (req_type 1). Output channel o_valid/i_stall carries one result
// per completed frame, and one per flush while detection is enabled.
// The front end takes magnitudes in stage 1 and squares in stage 2 and writes a
// two-entry queue; it stalls once the queue plus the word in the square stage
// would fill both entries.
// The back end runs a restoring divider, one quotient bit a cycle: a sample
// passes through ST_IDLE and ST_PDIV, a frame-ending sample then through
// ST_MDIV for the 32-bit mean division and ST_DET for the detectors. The back
// end pops no new sample from the queue until it is back in ST_IDLE.
// The result sits in an output register until taken; while i_stall is high
// the back end holds and the queue fills, then o_stall rises.
// Reset (i_rst_n low, synchronous) restores register defaults, clears frame
// time, sums and both region detectors, and empties the queue.
// Config writes are taken on i_cfg_we at any edge, intended only while idle.
module stereo_phase_correlation_detector_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [spcd_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [spcd_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic                              i_req_type,
    input  logic signed [spcd_pkg::SAMPLE_BITS-1:0] i_left_sample,
    input  logic signed [spcd_pkg::SAMPLE_BITS-1:0] i_right_sample,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic signed [15:0]                o_mean_phase,
    output logic [1:0]                        o_mono_event,
    output logic [spcd_pkg::TIME_BITS-1:0]    o_mono_time,
    output logic [spcd_pkg::TIME_BITS-1:0]    o_mono_length,
    output logic [1:0]                        o_out_event,
    output logic [spcd_pkg::TIME_BITS-1:0]    o_out_time,
    output logic [spcd_pkg::TIME_BITS-1:0]    o_out_length
);
    import spcd_pkg::*;

    logic [FLEN_BITS-1:0] r_frame_len;
    logic [14:0]          r_mono_thr;
    logic signed [15:0]   r_out_thr;
    logic [TIME_BITS-1:0] r_min_dur;
    logic                 r_det_en;
    logic                 q_valid, q_pop;
    t_req                 q_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_len <= 16'd1920;
            r_mono_thr  <= 15'd32767;
            r_out_thr   <= -16'sd32270;
            r_min_dur   <= TIME_BITS'(96000);
            r_det_en    <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_FRAME_LEN: r_frame_len <= i_cfg_data[15:0];
                REG_MONO_THR:  r_mono_thr  <= i_cfg_data[14:0];
                REG_OUT_THR:   r_out_thr   <= i_cfg_data[15:0];
                REG_MIN_DUR:   r_min_dur   <= i_cfg_data[TIME_BITS-1:0];
                REG_DETECT_EN: r_det_en    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    spcd_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_req_type,
        .i_left_sample, .i_right_sample, .i_detect_en(r_det_en),
        .o_q_valid(q_valid), .o_q_req(q_req), .i_q_pop(q_pop)
    );

    spcd_back u_back (
        .i_clk, .i_rst_n, .i_q_valid(q_valid), .i_q_req(q_req), .o_q_pop(q_pop),
        .i_frame_len(r_frame_len), .i_mono_thr(r_mono_thr), .i_out_thr(r_out_thr),
        .i_min_dur(r_min_dur), .i_detect_en(r_det_en),
        .o_valid, .i_stall, .o_mean_phase, .o_mono_event, .o_mono_time,
        .o_mono_length, .o_out_event, .o_out_time, .o_out_length
    );
endmodule

>>> hw/rtl/spcd_checker.sv
// spcd_checker: port-level checks on the phase meter, bound to the top level
// depends on spcd_pkg
module spcd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_stall,
    input logic signed [15:0] o_mean_phase,
    input logic [1:0]  o_mono_event,
    input logic [1:0]  o_out_event,
    input logic [spcd_pkg::TIME_BITS-1:0] o_mono_length
);
    import spcd_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_mean_phase))
        else $error("result changed while stalled");
    a_mev: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_mono_event != 2'd3 && o_out_event != 2'd3)
        else $error("bad event code");
    a_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_mono_event != EV_END |-> o_mono_length == '0)
        else $error("length without end event");
    a_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall |=> !o_valid)
        else $error("results back to back");
endmodule

bind stereo_phase_correlation_detector_top spcd_checker u_chk (
    .i_clk, .i_rst_n, .o_valid, .i_stall, .o_mean_phase,
    .o_mono_event, .o_out_event, .o_mono_length
);
